// ===== rtl/stam_pkg.sv =====
// ----------------------------------------------------------------------------
// stam_pkg: shared types and constants for the sparse transpose accumulator
// Word formats for the request and response channels, the accumulator
// entry layout and the command codes.
// ----------------------------------------------------------------------------
package stam_pkg;

   // Accumulator store geometry
   localparam int COLUMNS = 1024;
   localparam int ADDR_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

   // Field widths
   localparam int IDX_W = 10;
   localparam int VAL_W = 32;
   localparam int ACC_W = 48;

   // Command codes
   localparam logic CMD_ACCUM = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Request word
   typedef struct packed {
      logic                    cmd;
      logic [IDX_W-1:0]        column_index;
      logic signed [VAL_W-1:0] matrix_value;
      logic signed [VAL_W-1:0] vector_element;
   } req_type;

   // Response word
   typedef struct packed {
      logic signed [ACC_W-1:0] sum_value;
      logic                    saturated;
   } rsp_type;

   // One accumulator store entry
   typedef struct packed {
      logic                    sat;
      logic signed [ACC_W-1:0] acc;
   } entry_type;

endpackage

// ===== rtl/sparse_transpose_matvec_accum.sv =====
// ----------------------------------------------------------------------------
// sparse_transpose_matvec_accum: v = A^T b accumulator over sparse nonzeros
// Usage:
//   Request channel (req_*): one word per nonzero of a row-compressed
//   matrix. cmd = accumulate adds matrix_value * vector_element (Q16.16,
//   product truncated to Q32.16) into the entry at column_index with
//   saturation to 48 bits and a sticky saturation mark. cmd = read returns
//   the entry and its mark on the response channel (rsp_*) and clears both.
//   An accumulate word produces no response.
//   A request word is taken only in the idle state, so the next word waits
//   until the previous one is through. The entry lives in a single-port
//   synchronous memory; acceptance reads the entry and registers the product,
//   then the calc state adds, saturates and writes it back. A read's response
//   is loaded into an output register from the calc state, so the next request
//   is taken while a response still waits. A read request waits in the calc
//   state only while the previous response is stalled.
//   Reset: the store is swept to zero, one entry per cycle, through all
//   COLUMNS (1024) entries; req_stall stays high during the sweep.
//   Indexes at or beyond COLUMNS: accumulate is dropped, read returns zero.
// ----------------------------------------------------------------------------
module sparse_transpose_matvec_accum (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stam_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stam_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_CALC  = 3'b100
   } state_type;

   localparam int AW = stam_pkg::ADDR_W;
   localparam int CW = stam_pkg::ACC_W;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                 cmd_ff;
   logic                 hit_ff;
   logic [AW-1:0]        addr_ff;
   logic signed [CW-1:0] prod_ff;
   stam_pkg::entry_type  rd_entry_ff;
   stam_pkg::rsp_type    rsp_data_ff;
   logic                 rsp_valid_ff;

   stam_pkg::entry_type  mem [stam_pkg::COLUMNS];

   logic                 accept;
   logic                 in_range;
   logic                 rsp_free;
   logic signed [63:0]   mul_full;
   logic [CW:0]          sum_ext;
   logic                 ovf;
   logic [CW-1:0]        sum_sat;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   stam_pkg::entry_type  mem_wd;
   logic                 load_rsp;
   stam_pkg::rsp_type    rsp_next;

   // Handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign in_range  = (32'(req_data.column_index) < 32'(stam_pkg::COLUMNS));

   // Full product, truncated to Q32.16 when registered
   assign mul_full = req_data.matrix_value * req_data.vector_element;

   // Add and saturate to 48 bits
   assign sum_ext = {rd_entry_ff.acc[CW-1], rd_entry_ff.acc} + {prod_ff[CW-1], prod_ff};
   assign ovf     = sum_ext[CW] ^ sum_ext[CW-1];
   always_comb begin
      if (!ovf) begin
         sum_sat = sum_ext[CW-1:0];
      end else if (sum_ext[CW]) begin
         sum_sat = {1'b1, {(CW-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(CW-1){1'b1}}};
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      mem_we      = 1'b0;
      mem_wa      = addr_ff;
      mem_wd      = '0;
      load_rsp    = 1'b0;
      rsp_next    = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(stam_pkg::COLUMNS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            if (cmd_ff == stam_pkg::CMD_ACCUM) begin
               mem_we     = hit_ff;
               mem_wd.sat = rd_entry_ff.sat | ovf;
               mem_wd.acc = sum_sat;
               state_in   = ST_IDLE;
            end else if (rsp_free) begin
               // read and clear; out of range reads return zero
               load_rsp = 1'b1;
               mem_we   = hit_ff;
               if (hit_ff) begin
                  rsp_next.sum_value = rd_entry_ff.acc;
                  rsp_next.saturated = rd_entry_ff.sat;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Captured request and product
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_data.cmd;
         hit_ff  <= in_range;
         addr_ff <= AW'(req_data.column_index);
         prod_ff <= mul_full[63:16];
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_next;
      end
   end

   // Accumulator store: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (accept && in_range) begin
         rd_entry_ff <= mem[AW'(req_data.column_index)];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/stam_checker.sv =====
// ----------------------------------------------------------------------------
// stam_checker: port-level checks for the sparse transpose accumulator
// Watches the top level's channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module stam_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input stam_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input stam_pkg::rsp_type rsp_data
);

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response word changed");

   // Reset starts the clearing sweep with no response pending
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_stall && !rsp_valid)
      else $error("block not busy and empty after reset");

   // One word in flight: an accepted word blocks the next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while previous one in flight");

   // An accumulate word does not raise rsp_valid as its calc state ends
   a_accum_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.cmd == stam_pkg::CMD_ACCUM)
      |=> ##1 !$rose(rsp_valid))
      else $error("response produced for an accumulate word");

endmodule

bind sparse_transpose_matvec_accum stam_checker u_stam_checker (.*);
